>>> sv/riff_wave_chunk_parser_macros.svh
// ----------------------------------------------------------------------------
// RIFF wave chunk parser assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RIFF_WAVE_CHUNK_PARSER_MACROS_SVH
`define RIFF_WAVE_CHUNK_PARSER_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define RWCP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rwcp check failed");
// antecedent implies consequent in the next cycle
`define RWCP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rwcp check failed");
`else
`define RWCP_ASSERT_SAME(lbl, ante, cons)
`define RWCP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> sv/rwcp_pkg.sv
// ----------------------------------------------------------------------------
// RIFF wave chunk parser package
// Transaction types, phase encoding and chunk identifiers.
// ----------------------------------------------------------------------------
package rwcp_pkg;

	// result queue depth, in results
	localparam int RWCP_QUEUE_DEPTH = 8;

	// result kinds
	localparam logic [2:0] KIND_SAMPLE = 3'd0;
	localparam logic [2:0] KIND_FORMAT = 3'd1;
	localparam logic [2:0] KIND_DSIZE  = 3'd2;
	localparam logic [2:0] KIND_DONE   = 3'd3;
	localparam logic [2:0] KIND_ERROR  = 3'd4;

	// error codes
	localparam logic [1:0] ERR_RIFF_ID  = 2'd0;
	localparam logic [1:0] ERR_WAVE_ID  = 2'd1;
	localparam logic [1:0] ERR_SHORT    = 2'd2;
	localparam logic [1:0] ERR_NOT_PCM  = 2'd3;

	// ids, byte k of the stream at bits [8k+7:8k]
	localparam logic [31:0] RIFF_ID_LE = 32'h4646_4952;
	localparam logic [31:0] WAVE_ID_LE = 32'h4556_4157;
	// chunk ids as shifted in, first byte on top
	localparam logic [31:0] FMT_ID     = 32'h666D_7420;
	localparam logic [31:0] DATA_ID    = 32'h6461_7461;
	localparam logic [15:0] PCM_CODE   = 16'h0001;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_HEAD = 4'b0010,
		PH_CHDR = 4'b0100,
		PH_BODY = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		CK_OTHER = 2'd0,
		CK_FMT   = 2'd1,
		CK_DATA  = 2'd2
	} chunk_kind_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [30:0] total_length;
		logic        start_of_file;
	} byte_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  sample_byte;
		logic [15:0] num_channels;
		logic [31:0] sample_rate;
		logic [15:0] bits_per_sample;
		logic [31:0] data_size;
		logic [1:0]  error_code;
		logic        last_of_run;
	} result_item_t;

endpackage

>>> sv/riff_wave_chunk_parser.sv
// ----------------------------------------------------------------------------
// RIFF wave chunk parser
// Walks a WAV byte stream, reports format, data size, samples and status.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------
//  byte     | byte_valid/stall   | data byte, buffer length, start flag
//  result   | result_valid/stall | kind, sample, format, size, error, last
//
// One byte per cycle while byte_stall is low; the parse of a byte sits
// between the input register and a small result queue, which it writes.
// A byte that causes two results writes both into the queue together.
// byte_stall rises when the queue cannot take two more results beyond the
// byte in flight; it follows the queue fill, set by result_stall.
// Reset clears control state only; the parser waits for a start byte.
`include "riff_wave_chunk_parser_macros.svh"

module riff_wave_chunk_parser
	import rwcp_pkg::*;
#(
	parameter int DEPTH = RWCP_QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         byte_valid,
	output logic         byte_stall,
	input  byte_item_t   byte_item,
	output logic         result_valid,
	input  logic         result_stall,
	output result_item_t result_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	// input stage
	logic       valid_s1;
	byte_item_t item_s1;

	// parser state
	phase_t      phase_q;
	logic [32:0] file_offset_q;
	logic [31:0] riff_size_q;
	logic [31:0] chunk_id_q;
	logic [31:0] chunk_size_q;
	logic [31:0] chunk_pos_q;
	chunk_kind_t chunk_kind_q;
	logic [15:0] comp_word_q;
	logic [15:0] chan_word_q;
	logic [31:0] rate_word_q;

	// next state
	phase_t      phase_n;
	logic [32:0] file_offset_n;
	logic [31:0] riff_size_n;
	logic [31:0] chunk_id_n;
	logic [31:0] chunk_size_n;
	logic [31:0] chunk_pos_n;
	chunk_kind_t chunk_kind_n;
	logic [15:0] comp_word_n;
	logic [15:0] chan_word_n;
	logic [31:0] rate_word_n;
	logic        state_we;

	// results of the byte in stage 1
	result_item_t res0;
	result_item_t res1;
	logic [1:0]   n_push;
	logic         fail_c;

	// result queue
	result_item_t q_mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          pop;
	logic [CW:0]   need;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		r = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
		return r;
	endfunction

	// admit a byte only if the queue can absorb two results each for it and
	// the byte already in flight
	always_comb begin
		need = {1'b0, cnt_q} + (valid_s1 ? (CW+1)'(4) : (CW+1)'(2));
		byte_stall = (need > (CW+1)'(DEPTH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= byte_valid && !byte_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_item;
		end
	end

	// byte parse
	always_comb begin
		logic [7:0]  b;
		phase_t      ph;
		logic [32:0] off;
		logic [32:0] end_off;
		logic [2:0]  hp;
		logic [31:0] bp;
		logic [15:0] cw_hi;
		logic        main_v;
		logic        done_v;
		result_item_t main_r;
		result_item_t done_r;
		result_item_t err_r;

		b = item_s1.data_byte;

		// a start byte begins from the cleared file state
		if (item_s1.start_of_file) begin
			ph           = PH_HEAD;
			off          = '0;
			riff_size_n  = '0;
			chunk_id_n   = '0;
			chunk_size_n = '0;
			chunk_pos_n  = '0;
			chunk_kind_n = CK_OTHER;
			comp_word_n  = '0;
			chan_word_n  = '0;
			rate_word_n  = '0;
		end else begin
			ph           = phase_q;
			off          = file_offset_q;
			riff_size_n  = riff_size_q;
			chunk_id_n   = chunk_id_q;
			chunk_size_n = chunk_size_q;
			chunk_pos_n  = chunk_pos_q;
			chunk_kind_n = chunk_kind_q;
			comp_word_n  = comp_word_q;
			chan_word_n  = chan_word_q;
			rate_word_n  = rate_word_q;
		end

		phase_n       = ph;
		file_offset_n = off + 33'd1;
		end_off       = {1'b0, riff_size_n} + 33'd8;
		hp            = chunk_pos_n[2:0];
		bp            = chunk_pos_n;
		cw_hi         = comp_word_n | {b, 8'h00};
		main_v        = 1'b0;
		done_v        = 1'b0;
		fail_c        = 1'b0;
		main_r        = '0;
		done_r        = '0;
		err_r         = '0;
		err_r.kind    = KIND_ERROR;
		done_r.kind   = KIND_DONE;

		case (ph)
			PH_HEAD: begin
				if (off < 33'd4) begin
					if (b != RIFF_ID_LE[{off[1:0], 3'b000} +: 8]) begin
						fail_c           = 1'b1;
						err_r.error_code = ERR_RIFF_ID;
					end
				end else if (off < 33'd8) begin
					riff_size_n[{off[1:0], 3'b000} +: 8] =
						riff_size_n[{off[1:0], 3'b000} +: 8] | b;
				end else if (off < 33'd12) begin
					if (b != WAVE_ID_LE[{off[1:0], 3'b000} +: 8]) begin
						fail_c           = 1'b1;
						err_r.error_code = ERR_WAVE_ID;
					end
				end
				if (!fail_c && off == 33'd11) begin
					if ({2'b00, item_s1.total_length} < end_off) begin
						fail_c           = 1'b1;
						err_r.error_code = ERR_SHORT;
					end else begin
						phase_n     = PH_CHDR;
						chunk_pos_n = '0;
					end
				end
			end
			PH_CHDR: begin
				// id bytes shift in, size bytes land little-endian
				if (hp < 3'd4) begin
					chunk_id_n = {chunk_id_n[23:0], b};
				end else begin
					chunk_size_n[{hp[1:0], 3'b000} +: 8] =
						chunk_size_n[{hp[1:0], 3'b000} +: 8] | b;
				end
				chunk_pos_n = {29'd0, hp} + 32'd1;
				if (hp == 3'd7) begin
					if (chunk_id_n == FMT_ID) begin
						chunk_kind_n = CK_FMT;
					end else if (chunk_id_n == DATA_ID) begin
						chunk_kind_n = CK_DATA;
					end else begin
						chunk_kind_n = CK_OTHER;
					end
					if (chunk_kind_n == CK_DATA) begin
						main_v           = 1'b1;
						main_r.kind      = KIND_DSIZE;
						main_r.data_size = chunk_size_n;
					end
					chunk_pos_n = '0;
					if (chunk_size_n != 32'd0) begin
						phase_n = PH_BODY;
					end else begin
						chunk_id_n   = '0;
						chunk_size_n = '0;
					end
				end
			end
			PH_BODY: begin
				if (chunk_kind_n == CK_DATA) begin
					main_v             = 1'b1;
					main_r.kind        = KIND_SAMPLE;
					main_r.sample_byte = b;
				end else if (chunk_kind_n == CK_FMT) begin
					if (bp == 32'd0) begin
						comp_word_n = {8'h00, b};
					end else if (bp == 32'd1) begin
						comp_word_n = cw_hi;
						if (cw_hi != PCM_CODE) begin
							fail_c           = 1'b1;
							err_r.error_code = ERR_NOT_PCM;
						end
					end else if (bp < 32'd4) begin
						chan_word_n[{bp[0], 3'b000} +: 8] =
							chan_word_n[{bp[0], 3'b000} +: 8] | b;
					end else if (bp < 32'd8) begin
						rate_word_n[{bp[1:0], 3'b000} +: 8] =
							rate_word_n[{bp[1:0], 3'b000} +: 8] | b;
					end else if (bp == 32'd14) begin
						comp_word_n = {8'h00, b};
					end else if (bp == 32'd15) begin
						main_v                 = 1'b1;
						main_r.kind            = KIND_FORMAT;
						main_r.num_channels    = chan_word_n;
						main_r.sample_rate     = rate_word_n;
						main_r.bits_per_sample = cw_hi;
					end
				end
				chunk_pos_n = bp + 32'd1;
				if (bp + 32'd1 == chunk_size_n) begin
					phase_n      = PH_CHDR;
					chunk_pos_n  = '0;
					chunk_id_n   = '0;
					chunk_size_n = '0;
					chunk_kind_n = CK_OTHER;
					comp_word_n  = '0;
					chan_word_n  = '0;
					rate_word_n  = '0;
				end
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase

		// walk end
		if (ph != PH_IDLE && !fail_c && phase_n != PH_HEAD &&
		    file_offset_n >= end_off) begin
			done_v  = 1'b1;
			phase_n = PH_IDLE;
		end
		if (fail_c) begin
			phase_n = PH_IDLE;
		end

		// order the results and mark the last one
		res0   = '0;
		res1   = '0;
		n_push = 2'd0;
		if (ph != PH_IDLE) begin
			if (fail_c) begin
				res0             = err_r;
				res0.last_of_run = 1'b1;
				n_push           = 2'd1;
			end else if (main_v && done_v) begin
				res0             = main_r;
				res1             = done_r;
				res1.last_of_run = 1'b1;
				n_push           = 2'd2;
			end else if (main_v) begin
				res0             = main_r;
				res0.last_of_run = 1'b1;
				n_push           = 2'd1;
			end else if (done_v) begin
				res0             = done_r;
				res0.last_of_run = 1'b1;
				n_push           = 2'd1;
			end
		end
		if (!valid_s1) begin
			n_push = 2'd0;
		end
		state_we = valid_s1 && (ph != PH_IDLE);
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			file_offset_q <= '0;
			riff_size_q   <= '0;
			chunk_id_q    <= '0;
			chunk_size_q  <= '0;
			chunk_pos_q   <= '0;
			chunk_kind_q  <= CK_OTHER;
			comp_word_q   <= '0;
			chan_word_q   <= '0;
			rate_word_q   <= '0;
		end else if (state_we) begin
			phase_q       <= phase_n;
			file_offset_q <= file_offset_n;
			riff_size_q   <= riff_size_n;
			chunk_id_q    <= chunk_id_n;
			chunk_size_q  <= chunk_size_n;
			chunk_pos_q   <= chunk_pos_n;
			chunk_kind_q  <= chunk_kind_n;
			comp_word_q   <= comp_word_n;
			chan_word_q   <= chan_word_n;
			rate_word_q   <= rate_word_n;
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			q_mem[wr_ptr_q] <= res0;
		end
		if (n_push == 2'd2) begin
			q_mem[ptr_inc(wr_ptr_q)] <= res1;
		end
	end

	assign result_valid = (cnt_q != '0);
	assign result_item  = q_mem[rd_ptr_q];
	assign pop          = result_valid && !result_stall;

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (n_push == 2'd1) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end else if (n_push == 2'd2) begin
				wr_ptr_q <= ptr_inc(ptr_inc(wr_ptr_q));
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			cnt_q <= cnt_q + CW'(n_push) - CW'(pop);
		end
	end

	`RWCP_ASSERT_SAME(a_fill_bound, 1'b1, cnt_q <= CW'(DEPTH))
	`RWCP_ASSERT_SAME(a_room_for_byte, valid_s1, ({1'b0, cnt_q} + (CW+1)'(2)) <= (CW+1)'(DEPTH))
	`RWCP_ASSERT_NEXT(a_error_stops, valid_s1 && fail_c, phase_q == PH_IDLE)
	`RWCP_ASSERT_SAME(a_done_is_last, result_valid && result_item.kind == KIND_DONE, result_item.last_of_run)

endmodule

>>> sim/riff_wave_chunk_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RIFF wave chunk parser testbench
// Sends WAV byte streams: a few fixed header cases, then random files that
// are mostly well formed. Files carry fmt, data and other chunks, and some
// have bad ids, short buffers, odd RIFF sizes or non-PCM formats. A
// scoreboard walks each accepted byte the way the parser should and checks
// every result transaction in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
	import rwcp_pkg::*;

	// expected parser behavior, byte by byte, and the results still owed
	class chunk_walk_board;
		result_item_t awaited_results[$];
		int unsigned  mismatches;

		phase_t      phase;
		logic [32:0] file_offset;
		logic [31:0] riff_size;
		logic [31:0] chunk_id_shift;
		logic [31:0] chunk_size;
		logic [31:0] chunk_position;
		chunk_kind_t chunk_kind;
		logic [15:0] compression_word;
		logic [15:0] channels_word;
		logic [31:0] rate_word;

		function new();
			mismatches = 0;
			phase = PH_IDLE;
			clear_file();
		endfunction

		function void clear_file();
			file_offset = '0;
			riff_size = '0;
			chunk_id_shift = '0;
			chunk_size = '0;
			chunk_position = '0;
			chunk_kind = CK_OTHER;
			compression_word = '0;
			channels_word = '0;
			rate_word = '0;
		endfunction

		function void queue_result(logic [2:0] kind, logic [7:0] sample, logic [15:0] chans,
				logic [31:0] rate, logic [15:0] bits, logic [31:0] dsize, logic [1:0] code);
			result_item_t r;
			r = '{kind, sample, chans, rate, bits, dsize, code, 1'b0};
			awaited_results.push_back(r);
		endfunction

		// an error is the only result of its byte and stops the walk
		function void raise(logic [1:0] code);
			result_item_t r;
			r = '{KIND_ERROR, 8'd0, 16'd0, 32'd0, 16'd0, 32'd0, code, 1'b1};
			awaited_results.push_back(r);
			phase = PH_IDLE;
		endfunction

		function void take_byte(byte_item_t item);
			logic [7:0]  b;
			logic [32:0] off;
			logic [32:0] walk_end;
			logic [2:0]  p;
			logic [31:0] pos;
			int unsigned first;
			result_item_t r;
			b = item.data_byte;
			first = awaited_results.size();
			if (item.start_of_file) begin
				clear_file();
				phase = PH_HEAD;
			end
			if (phase == PH_IDLE)
				return;
			off = file_offset;
			file_offset = file_offset + 33'd1;
			walk_end = 33'd8 + 33'(riff_size);

			case (phase)
				// RIFF id, RIFF size, WAVE id, then the length check
				PH_HEAD: begin
					if (off < 33'd4) begin
						if (b != RIFF_ID_LE[8*off[1:0] +: 8]) begin
							raise(ERR_RIFF_ID);
							return;
						end
					end else if (off < 33'd8) begin
						riff_size = riff_size | (32'(b) << (8*off[1:0]));
					end else if (off < 33'd12) begin
						if (b != WAVE_ID_LE[8*off[1:0] +: 8]) begin
							raise(ERR_WAVE_ID);
							return;
						end
					end
					if (off == 33'd11) begin
						walk_end = 33'd8 + 33'(riff_size);
						if (33'(item.total_length) < walk_end) begin
							raise(ERR_SHORT);
							return;
						end
						phase = PH_CHDR;
						chunk_position = '0;
					end
				end
				// chunk header: id first byte on top, size little endian
				PH_CHDR: begin
					p = chunk_position[2:0];
					if (p < 3'd4)
						chunk_id_shift = {chunk_id_shift[23:0], b};
					else
						chunk_size = chunk_size | (32'(b) << (8*p[1:0]));
					chunk_position = 32'(p) + 32'd1;
					if (p == 3'd7) begin
						if (chunk_id_shift == FMT_ID)
							chunk_kind = CK_FMT;
						else if (chunk_id_shift == DATA_ID)
							chunk_kind = CK_DATA;
						else
							chunk_kind = CK_OTHER;
						if (chunk_kind == CK_DATA)
							queue_result(KIND_DSIZE, 8'd0, 16'd0, 32'd0, 16'd0, chunk_size, 2'd0);
						chunk_position = '0;
						if (chunk_size != 32'd0) begin
							phase = PH_BODY;
						end else begin
							chunk_id_shift = '0;
							chunk_size = '0;
						end
					end
				end
				// chunk body: samples pass through, fmt fields gathered
				default: begin
					pos = chunk_position;
					if (chunk_kind == CK_DATA) begin
						queue_result(KIND_SAMPLE, b, 16'd0, 32'd0, 16'd0, 32'd0, 2'd0);
					end else if (chunk_kind == CK_FMT) begin
						if (pos == 32'd0) begin
							compression_word = {8'd0, b};
						end else if (pos == 32'd1) begin
							compression_word = compression_word | {b, 8'd0};
							if (compression_word != PCM_CODE) begin
								raise(ERR_NOT_PCM);
								return;
							end
						end else if (pos < 32'd4) begin
							channels_word = channels_word | (16'(b) << (8*pos[0]));
						end else if (pos < 32'd8) begin
							rate_word = rate_word | (32'(b) << (8*pos[1:0]));
						end else if (pos == 32'd14) begin
							compression_word = {8'd0, b};
						end else if (pos == 32'd15) begin
							queue_result(KIND_FORMAT, 8'd0, channels_word, rate_word,
								compression_word | {b, 8'd0}, 32'd0, 2'd0);
						end
					end
					chunk_position = pos + 32'd1;
					if (chunk_position == chunk_size) begin
						phase = PH_CHDR;
						chunk_position = '0;
						chunk_id_shift = '0;
						chunk_size = '0;
						chunk_kind = CK_OTHER;
						compression_word = '0;
						channels_word = '0;
						rate_word = '0;
					end
				end
			endcase

			// walk ends at 8 + RIFF size, even mid chunk
			if (phase != PH_HEAD && file_offset >= walk_end) begin
				queue_result(KIND_DONE, 8'd0, 16'd0, 32'd0, 16'd0, 32'd0, 2'd0);
				phase = PH_IDLE;
			end
			if (awaited_results.size() > first) begin
				r = awaited_results.pop_back();
				r.last_of_run = 1'b1;
				awaited_results.push_back(r);
			end
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
				mismatches++;
			end
		endfunction

		function void match_result(result_item_t got);
			result_item_t want;
			if (awaited_results.size() == 0) begin
				$error("result transaction with none expected: kind 0x%0h", got.kind);
				mismatches++;
				return;
			end
			want = awaited_results.pop_front();
			compare("kind", 32'(want.kind), 32'(got.kind));
			compare("sample_byte", 32'(want.sample_byte), 32'(got.sample_byte));
			compare("num_channels", 32'(want.num_channels), 32'(got.num_channels));
			compare("sample_rate", want.sample_rate, got.sample_rate);
			compare("bits_per_sample", 32'(want.bits_per_sample), 32'(got.bits_per_sample));
			compare("data_size", want.data_size, got.data_size);
			compare("error_code", 32'(want.error_code), 32'(got.error_code));
			compare("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         byte_valid;
	logic         byte_stall;
	byte_item_t   byte_item;
	logic         result_valid;
	logic         result_stall = 1'b0;
	result_item_t result_item;

	bit           calm = 1'b0;
	int unsigned  stall_hold = 0;
	chunk_walk_board walk_board = new();

	riff_wave_chunk_parser u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_item    (byte_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// idle length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side back-pressure
	always @(posedge clk) begin
		if (stall_hold != 0) begin
			stall_hold <= stall_hold - 1;
		end else if (calm || result_stall) begin
			result_stall <= 1'b0;
			stall_hold <= calm ? 0 : $urandom_range(0, 12);
		end else begin
			result_stall <= 1'b1;
			stall_hold <= pick_gap();
		end
	end

	// values seen at the falling edge hold through the next rising edge
	always @(negedge clk) begin
		if (arst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
			walk_board.match_result(result_item);
	end

	task automatic send_byte(input logic [7:0] value, input logic [30:0] buf_len,
			input logic sof);
		int unsigned gap;
		byte_item_t  item;
		item = {value, buf_len, sof};
		gap = pick_gap();
		if (gap != 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= item;
		@(negedge clk);
		while (byte_stall !== 1'b0) @(negedge clk);
		walk_board.take_byte(item);
		@(posedge clk);
	endtask

	task automatic send_file(input logic [7:0] img[$], input logic [30:0] buf_len);
		foreach (img[i])
			send_byte(img[i], buf_len, i == 0);
	endtask

	function automatic void add_chunk(ref logic [7:0] img[$], input logic [31:0] id,
			input logic [7:0] content[$]);
		for (int i = 3; i >= 0; i--)
			img.push_back(id[8*i +: 8]);
		for (int i = 0; i < 4; i++)
			img.push_back(8'(content.size() >> (8*i)));
		img = {img, content};
	endfunction

	// one random WAV image, usually well formed, sometimes flawed on purpose
	task automatic make_wave_file(output logic [7:0] img[$], output logic [30:0] buf_len);
		logic [7:0]   body[$];
		logic [7:0]   content[$];
		logic [127:0] fmt_raw;
		logic [31:0]  riff_len;
		logic [31:0]  walk_end;
		logic [31:0]  id;
		logic [15:0]  comp;
		int unsigned  nchunks;
		int unsigned  flaw;
		int unsigned  fmt_len;
		int unsigned  r;
		int unsigned  keep;
		body = {};
		nchunks = $urandom_range(0, 3);
		for (int k = 0; k < nchunks; k++) begin
			content = {};
			r = $urandom_range(0, 9);
			if ((k == 0 && r < 8) || r == 9) begin
				comp = ($urandom_range(0, 9) < 8) ? PCM_CODE : 16'($urandom);
				fmt_raw = {16'($urandom), 16'($urandom), 32'($urandom), 32'($urandom),
					16'($urandom), comp};
				r = $urandom_range(0, 9);
				fmt_len = (r < 6) ? 16 : (r < 8) ? 18 : $urandom_range(0, 15);
				for (int i = 0; i < fmt_len; i++)
					content.push_back(i < 16 ? fmt_raw[8*i +: 8] : 8'($urandom));
				add_chunk(body, FMT_ID, content);
			end else if ($urandom_range(0, 1) == 1) begin
				repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8))
					content.push_back(8'($urandom));
				add_chunk(body, DATA_ID, content);
			end else begin
				// unknown chunk, sometimes one bit off a known id
				if ($urandom_range(0, 2) == 0)
					id = ($urandom_range(0, 1) ? FMT_ID : DATA_ID)
						^ (32'd1 << $urandom_range(0, 31));
				else
					id = $urandom;
				repeat ($urandom_range(0, 5))
					content.push_back(8'($urandom));
				add_chunk(body, id, content);
			end
		end

		riff_len = 32'd4 + body.size();
		flaw = $urandom_range(0, 99);
		if (flaw >= 60 && flaw < 70)
			riff_len = $urandom_range(0, riff_len);
		else if (flaw >= 70 && flaw < 75)
			riff_len = riff_len + $urandom_range(1, 8);
		else if (flaw >= 95)
			riff_len = $urandom;
		walk_end = riff_len + 32'd8;
		if (flaw >= 95)
			buf_len = 31'($urandom);
		else if (flaw >= 75 && flaw < 83)
			buf_len = 31'($urandom_range(0, walk_end - 1));
		else if ($urandom_range(0, 4) == 0)
			buf_len = 31'($urandom_range(walk_end, 32'h7FFF_FFFF));
		else
			buf_len = 31'(walk_end + $urandom_range(0, 3));

		img = {};
		for (int i = 0; i < 4; i++)
			img.push_back(RIFF_ID_LE[8*i +: 8]);
		for (int i = 0; i < 4; i++)
			img.push_back(riff_len[8*i +: 8]);
		for (int i = 0; i < 4; i++)
			img.push_back(WAVE_ID_LE[8*i +: 8]);
		img = {img, body};

		// broken files are cut to the header or the flawed byte plus a short tail
		keep = img.size();
		if (flaw >= 83 && flaw < 95) begin
			r = (flaw < 89) ? $urandom_range(0, 3) : $urandom_range(8, 11);
			img[r] = img[r] ^ 8'($urandom_range(1, 255));
			keep = r + 1 + $urandom_range(0, 3);
		end else if ((flaw >= 75 && flaw < 83) || flaw >= 95) begin
			keep = 12 + $urandom_range(0, 3);
		end
		while (img.size() > keep)
			void'(img.pop_back());
	endtask

	initial begin
		logic [7:0]  img[$];
		logic [30:0] buf_len;
		int unsigned sent;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_item = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bytes before any start are ignored
		send_byte(8'hFF, 31'h7FFF_FFFF, 1'b0);
		send_byte(8'h00, 31'd0, 1'b0);
		// RIFF id wrong on its second byte
		send_file('{8'h52, 8'h58}, 31'd0);
		// all-ones RIFF size, WAVE id wrong on its first byte
		send_file('{8'h52, 8'h49, 8'h46, 8'h46, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h58},
			31'h7FFF_FFFF);
		// RIFF size 4: walk done on the last header byte
		send_file('{8'h52, 8'h49, 8'h46, 8'h46, 8'h04, 8'h00, 8'h00, 8'h00,
			8'h57, 8'h41, 8'h56, 8'h45}, 31'd12);

		// random files with stray bytes between them
		sent = 0;
		while (sent < 360) begin
			calm = ($urandom_range(0, 3) == 0);
			make_wave_file(img, buf_len);
			send_file(img, buf_len);
			sent += img.size();
			repeat ($urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 3))
				send_byte(8'($urandom), 31'($urandom), 1'b0);
		end
		byte_valid <= 1'b0;
		calm = 1'b1;

		// drain, then give late or extra results time to show up
		while (walk_board.awaited_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (walk_board.mismatches == 0)
			$display("riff_wave_chunk_parser regression: pass");
		else
			$display("riff_wave_chunk_parser regression: fail");
		$finish;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("riff_wave_chunk_parser regression: fail");
		$finish;
	end

endmodule
